### hw/rtl/bra_pkg.sv
// Shared types and constants for the bitmap run allocator.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package bra_pkg;

  localparam int CMD_W       = 2;
  localparam int IDX_W       = 10;
  localparam int LEN_W       = 11;
  localparam int CFG_W       = 8;
  localparam int LIM_W       = 11;  // eight times the largest register value
  localparam int WORD_W      = 32;  // map word width, one word per scan cycle
  localparam int WORD_BITS_W = 5;   // bit position within a map word
  localparam int CNT_W       = 12;  // free-run counter, holds limit plus one word
  localparam int WCNT_W      = 7;   // word counter, holds the word count itself

  localparam logic [CMD_W-1:0] CMD_TEST  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

  // Outcome of evaluating one map word during a scan
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] start;
    logic [CNT_W-1:0] carry;
  } bra_scan_res_t;

endpackage

`default_nettype wire

### hw/rtl/bra_in_if.sv
// Command channel of the bitmap run allocator: valid/ready plus one command.
// Depends on bra_pkg for field widths.
`default_nettype none

interface bra_in_if import bra_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [IDX_W-1:0] bit_index;
  logic             bit_value;
  logic [LEN_W-1:0] run_length;

  modport source (output valid, command, bit_index, bit_value, run_length, input ready);
  modport sink   (input valid, command, bit_index, bit_value, run_length, output ready);
endinterface

`default_nettype wire

### hw/rtl/bra_out_if.sv
// Result channel of the bitmap run allocator: valid/ready plus one result.
// Depends on bra_pkg for field widths.
`default_nettype none

interface bra_out_if import bra_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] run_start;
  logic             bit_read;
  logic             error;

  modport source (output valid, found, run_start, bit_read, error, input ready);
  modport sink   (input valid, found, run_start, bit_read, error, output ready);
endinterface

`default_nettype wire

### hw/rtl/bra_run_finder.sv
// Scan datapath: evaluates one 32-bit map word against the wanted run length.
// Depends on bra_pkg; used by bitmap_run_allocator_unit once per scan cycle.
`default_nettype none

module bra_run_finder import bra_pkg::*; (
  input  wire logic [WORD_W-1:0] word,
  input  wire logic [CNT_W-1:0]  carry_in,
  input  wire logic [LIM_W-1:0]  base,
  input  wire logic [LIM_W-1:0]  limit,
  input  wire logic [LEN_W-1:0]  run_len,
  output bra_scan_res_t          res
);

  logic [WORD_BITS_W-1:0] hi_one [WORD_W];
  logic [WORD_W-1:0]      any_one;
  logic [CNT_W-1:0]       run_cnt [WORD_W];
  logic [WORD_W-1:0]      hit;
  logic [LIM_W:0]         pos;
  logic [WORD_BITS_W-1:0] sel;
  logic [LIM_W:0]         start_w;

  // highest used bit at or below each position
  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      hi_one[j]  = '0;
      any_one[j] = 1'b0;
      for (int k = 0; k <= j; k++) begin
        if (word[k]) begin
          any_one[j] = 1'b1;
          hi_one[j]  = WORD_BITS_W'(k);
        end
      end
    end
  end

  // free-run length ending at each position, and whether it satisfies the request
  always_comb begin
    pos = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (any_one[j]) begin
        run_cnt[j] = CNT_W'(j) - CNT_W'(hi_one[j]);
      end else begin
        run_cnt[j] = carry_in + CNT_W'(j + 1);
      end
      pos    = {1'b0, base} + (LIM_W + 1)'(j);
      hit[j] = ~word[j] && (pos < {1'b0, limit}) && (run_cnt[j] >= {1'b0, run_len});
    end
  end

  // lowest hit wins
  always_comb begin
    sel = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (hit[j]) begin
        sel = WORD_BITS_W'(j);
      end
    end
    start_w = {1'b0, base} + (LIM_W + 1)'(sel) + (LIM_W + 1)'(1) - {1'b0, run_len};
    res.hit   = |hit;
    res.start = start_w[IDX_W-1:0];
    if (any_one[WORD_W-1]) begin
      res.carry = CNT_W'(WORD_W - 1) - CNT_W'(hi_one[WORD_W-1]);
    end else begin
      res.carry = carry_in + CNT_W'(WORD_W);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bitmap_run_allocator_unit.sv
// Bitmap run allocator, top level: command sequencer, map memory and result register.
// Depends on bra_pkg, bra_in_if, bra_out_if and bra_run_finder.
`default_nettype none

// First-fit allocation bitmap of MAP_BYTES bytes held in a single-port-write,
// registered-read memory of 32-bit words (bit i lives in word i/32, bit i%32).
// One command is taken per beat on in_ch and gives one result beat on out_ch;
// the block takes no new command until the current one has finished, but a
// finished result may sit in the output register while the next command runs.
// Per command: test and write read the addressed word, then pick out the bit or
// modify it and write it back, then load the result register; an out-of-range
// index or a zero run length goes straight to the result. A scan reads one map
// word per cycle and evaluates it in bra_run_finder the cycle after, and ends
// early at the first fit. Clear-all sweeps the memory one word a cycle. After
// reset the same sweep runs once before the first command is taken; cfg writes
// are accepted throughout and must only be issued while no command is in
// flight. A bytes_in_use above MAP_BYTES counts as MAP_BYTES.

module bitmap_run_allocator_unit import bra_pkg::*; #(
  parameter int MAP_BYTES = 128
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  bra_in_if.sink                in_ch,
  bra_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int WORDS = (MAP_BYTES + 3) / 4;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
  localparam int EFF_W = 14;
  localparam logic [EFF_W-1:0] MAP_BYTES_C = EFF_W'(MAP_BYTES);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_BIT  = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  // control state
  logic [2:0]        state_r,     state_nxt;
  logic [AW-1:0]     clr_addr_r,  clr_addr_nxt;
  logic              clr_cmd_r,   clr_cmd_nxt;
  logic [WCNT_W-1:0] rd_w_r,      rd_w_nxt;
  logic [WCNT_W-1:0] eval_w_r,    eval_w_nxt;
  logic              eval_vld_r,  eval_vld_nxt;
  logic [CNT_W-1:0]  carry_r,     carry_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CFG_W-1:0]  bytes_r,     bytes_nxt;

  // latched command
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              val_r, val_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;

  // pending result and output register
  logic              res_found_r, res_found_nxt;
  logic [IDX_W-1:0]  res_start_r, res_start_nxt;
  logic              res_read_r,  res_read_nxt;
  logic              res_err_r,   res_err_nxt;
  logic              out_found_r, out_found_nxt;
  logic [IDX_W-1:0]  out_start_r, out_start_nxt;
  logic              out_read_r,  out_read_nxt;
  logic              out_err_r,   out_err_nxt;

  // map memory
  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [WORD_W-1:0] mem_wd;
  logic [AW-1:0]     mem_ra;

  // derived limits
  logic [EFF_W-1:0]  cfg_ext;
  logic [CFG_W-1:0]  bytes_eff;
  logic [LIM_W-1:0]  limit;
  logic [CFG_W:0]    nw_sum;
  logic [WCNT_W-1:0] nwords;

  logic [AW+WORD_BITS_W-IDX_W+IDX_W-1:0] idx_addr_ext;
  logic [AW+WCNT_W-1:0]                  scan_addr_ext;
  logic [AW-1:0]                         idx_addr;
  logic [AW-1:0]                         scan_addr;
  logic [LIM_W-1:0]                      scan_base;
  bra_scan_res_t                         fres;

  always_comb begin
    cfg_ext   = {{(EFF_W - CFG_W){1'b0}}, bytes_r};
    bytes_eff = (cfg_ext > MAP_BYTES_C) ? MAP_BYTES_C[CFG_W-1:0] : bytes_r;
    limit     = {bytes_eff, 3'b000};
    nw_sum    = {1'b0, bytes_eff} + (CFG_W + 1)'(3);
    nwords    = nw_sum[CFG_W:2];
  end

  // word addresses, widened then cut to the memory's address width
  always_comb begin
    idx_addr_ext  = {{AW{1'b0}}, idx_r[IDX_W-1:WORD_BITS_W]};
    idx_addr      = idx_addr_ext[AW-1:0];
    scan_addr_ext = {{AW{1'b0}}, rd_w_r};
    scan_addr     = scan_addr_ext[AW-1:0];
    scan_base     = {eval_w_r[WCNT_W-2:0], {WORD_BITS_W{1'b0}}};
  end

  bra_run_finder u_finder (
    .word     (rd_data_r),
    .carry_in (carry_r),
    .base     (scan_base),
    .limit    (limit),
    .run_len  (len_r),
    .res      (fres)
  );

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.found     = out_found_r;
  assign out_ch.run_start = out_start_r;
  assign out_ch.bit_read  = out_read_r;
  assign out_ch.error     = out_err_r;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    clr_cmd_nxt   = clr_cmd_r;
    rd_w_nxt      = rd_w_r;
    eval_w_nxt    = eval_w_r;
    eval_vld_nxt  = eval_vld_r;
    carry_nxt     = carry_r;
    out_valid_nxt = out_valid_r;
    bytes_nxt     = cfg_we ? cfg_data : bytes_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    len_nxt       = len_r;
    res_found_nxt = res_found_r;
    res_start_nxt = res_start_r;
    res_read_nxt  = res_read_r;
    res_err_nxt   = res_err_r;
    out_found_nxt = out_found_r;
    out_start_nxt = out_start_r;
    out_read_nxt  = out_read_r;
    out_err_nxt   = out_err_r;
    mem_we        = 1'b0;
    mem_wa        = idx_addr;
    mem_wd        = rd_data_r;
    mem_ra        = idx_addr;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr_r;
        mem_wd = '0;
        if (clr_addr_r == LAST_WORD) begin
          clr_addr_nxt = '0;
          state_nxt    = clr_cmd_r ? ST_DONE : ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end

      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt       = in_ch.command;
          idx_nxt       = in_ch.bit_index;
          val_nxt       = in_ch.bit_value;
          len_nxt       = in_ch.run_length;
          res_found_nxt = 1'b0;
          res_start_nxt = '0;
          res_read_nxt  = 1'b0;
          res_err_nxt   = 1'b0;
          case (in_ch.command)
            CMD_TEST, CMD_WRITE: begin
              if ({1'b0, in_ch.bit_index} >= limit) begin
                res_err_nxt = 1'b1;
                state_nxt   = ST_DONE;
              end else begin
                state_nxt   = ST_RD;
              end
            end
            CMD_SCAN: begin
              rd_w_nxt     = '0;
              eval_vld_nxt = 1'b0;
              carry_nxt    = '0;
              if (in_ch.run_length == '0) begin
                res_err_nxt = 1'b1;
                state_nxt   = ST_DONE;
              end else if (nwords == '0) begin
                state_nxt   = ST_DONE;
              end else begin
                state_nxt   = ST_SCAN;
              end
            end
            CMD_CLEAR: begin
              clr_cmd_nxt  = 1'b1;
              clr_addr_nxt = '0;
              state_nxt    = ST_CLR;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_RD: begin
        // read of the addressed word is in flight
        state_nxt = ST_BIT;
      end

      ST_BIT: begin
        if (cmd_r == CMD_TEST) begin
          res_read_nxt = rd_data_r[idx_r[WORD_BITS_W-1:0]];
        end else begin
          mem_we = 1'b1;
          mem_wd[idx_r[WORD_BITS_W-1:0]] = val_r;
        end
        state_nxt = ST_DONE;
      end

      ST_SCAN: begin
        // read word rd_w_r while the finder checks word eval_w_r
        mem_ra     = scan_addr;
        eval_w_nxt = rd_w_r;
        if (rd_w_r < nwords) begin
          rd_w_nxt     = rd_w_r + WCNT_W'(1);
          eval_vld_nxt = 1'b1;
        end else begin
          eval_vld_nxt = 1'b0;
        end
        if (eval_vld_r) begin
          if (fres.hit) begin
            res_found_nxt = 1'b1;
            res_start_nxt = fres.start;
            state_nxt     = ST_DONE;
          end else begin
            carry_nxt = fres.carry;
            if (eval_w_r == nwords - WCNT_W'(1)) begin
              state_nxt = ST_DONE;
            end
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_start_nxt = res_start_r;
          out_read_nxt  = res_read_r;
          out_err_nxt   = res_err_r;
          clr_cmd_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      clr_cmd_r   <= 1'b0;
      rd_w_r      <= '0;
      eval_w_r    <= '0;
      eval_vld_r  <= 1'b0;
      carry_r     <= '0;
      out_valid_r <= 1'b0;
      bytes_r     <= CFG_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_cmd_r   <= clr_cmd_nxt;
      rd_w_r      <= rd_w_nxt;
      eval_w_r    <= eval_w_nxt;
      eval_vld_r  <= eval_vld_nxt;
      carry_r     <= carry_nxt;
      out_valid_r <= out_valid_nxt;
      bytes_r     <= bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    idx_r       <= idx_nxt;
    val_r       <= val_nxt;
    len_r       <= len_nxt;
    res_found_r <= res_found_nxt;
    res_start_r <= res_start_nxt;
    res_read_r  <= res_read_nxt;
    res_err_r   <= res_err_nxt;
    out_found_r <= out_found_nxt;
    out_start_r <= out_start_nxt;
    out_read_r  <= out_read_nxt;
    out_err_r   <= out_err_nxt;
  end

endmodule

`default_nettype wire
